// ----- design/tgmv_pkg.sv -----
`default_nettype none

package tgmv_pkg;

   // internal counter widths
   localparam int DIM_BITS   = 16;
   localparam int COUNT_BITS = 32;

   // result field widths, fixed by the port
   localparam int STATUS_BITS    = 3;
   localparam int ROW_FIELD_BITS = 16;
   localparam int OBS_FIELD_BITS = 32;
   localparam int CHAR_BITS      = 8;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
   localparam int                   RADIX        = 10;

   typedef logic [DIM_BITS-1:0]   dim_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CHAR_BITS-1:0]  char_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_RUN     = 3'd0,
      ST_HEADER  = 3'd1,
      ST_BADCHAR = 3'd2,
      ST_WIDTH   = 3'd3,
      ST_ROWS    = 3'd4,
      ST_VALID   = 3'd5
   } status_type;

   typedef struct packed {
      status_type                status;
      logic [ROW_FIELD_BITS-1:0] row_width;
      logic [ROW_FIELD_BITS-1:0] rows_seen;
      logic [OBS_FIELD_BITS-1:0] obstacles_seen;
      char_type                  empty_symbol;
      char_type                  obstacle_symbol;
      char_type                  full_symbol;
   } result_type;

endpackage

`default_nettype wire

// ----- design/tgmv_req_if.sv -----
`default_nettype none

interface tgmv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_file;

   modport source (output valid, output char_in, output end_of_file, input ready);
   modport sink   (input valid, input char_in, input end_of_file, output ready);
endinterface

`default_nettype wire

// ----- design/tgmv_rsp_if.sv -----
`default_nettype none

interface tgmv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] row_width;
   logic [15:0] rows_seen;
   logic [31:0] obstacles_seen;
   logic [7:0]  empty_symbol;
   logic [7:0]  obstacle_symbol;
   logic [7:0]  full_symbol;

   modport source (output valid, output status, output row_width, output rows_seen,
                   output obstacles_seen, output empty_symbol, output obstacle_symbol,
                   output full_symbol, input ready);
   modport sink   (input valid, input status, input row_width, input rows_seen,
                   input obstacles_seen, input empty_symbol, input obstacle_symbol,
                   input full_symbol, output ready);
endinterface

`default_nettype wire

// ----- design/text_grid_map_validator.sv -----
`default_nettype none

// Channel  Dir  Payload                                        Handshake
// req      in   char_in, end_of_file                           valid/ready
// rsp      out  status, row_width, rows_seen, obstacles_seen,  valid/ready
//               empty_symbol, obstacle_symbol, full_symbol
//
// One request per cycle unless rsp stalls; results show the next cycle.
// Latency and rate are set by the single result register after the core.
// Reset is synchronous and returns the parser to the first header digit.
// A stalled result holds in its register; a new request is taken in the
// same cycle that the waiting result leaves.

module text_grid_map_validator (
   input  wire logic  clock,
   input  wire logic  reset,
   tgmv_req_if.sink   req,
   tgmv_rsp_if.source rsp
);
   import tgmv_pkg::*;

   logic       take;
   result_type next_result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;

   // Take a request when the result register is empty or draining this cycle.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;

   // Parser state and the per-byte update; also rearms on the last byte.
   tgmv_core u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_in     (req.char_in),
      .end_of_file (req.end_of_file),
      .result      (next_result)
   );

   // Result register: control cleared by reset, payload loaded on take only.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= next_result;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_data_ff.status;
   assign rsp.row_width       = rsp_data_ff.row_width;
   assign rsp.rows_seen       = rsp_data_ff.rows_seen;
   assign rsp.obstacles_seen  = rsp_data_ff.obstacles_seen;
   assign rsp.empty_symbol    = rsp_data_ff.empty_symbol;
   assign rsp.obstacle_symbol = rsp_data_ff.obstacle_symbol;
   assign rsp.full_symbol     = rsp_data_ff.full_symbol;

endmodule

`default_nettype wire

// ----- design/tgmv_core.sv -----
`default_nettype none

module tgmv_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire tgmv_pkg::char_type  char_in,
   input  wire logic                end_of_file,
   output tgmv_pkg::result_type     result
);
   import tgmv_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST_DIGIT,
      PH_DIGITS,
      PH_SYM_OBST,
      PH_SYM_FULL,
      PH_HDR_NL,
      PH_BODY
   } phase_type;

   localparam int WIDE_BITS = DIM_BITS + 4;
   localparam dim_type   DIM_MAX   = '1;
   localparam count_type COUNT_MAX = '1;

   phase_type  phase_ff, phase_in;
   dim_type    declared_ff, declared_in;
   char_type   empty_ff, empty_in;
   char_type   obst_ff, obst_in;
   char_type   full_ff, full_in;
   dim_type    first_width_ff, first_width_in;
   dim_type    column_ff, column_in;
   dim_type    rows_ff, rows_in;
   count_type  obs_total_ff, obs_total_in;
   status_type error_ff, error_in;
   status_type status;

   logic                 is_digit;
   logic [WIDE_BITS-1:0] decl_wide;
   logic [WIDE_BITS-1:0] decl_next;

   assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign decl_wide = WIDE_BITS'(declared_ff);
   // times ten as two shifts, plus the digit (low nibble of an ASCII digit)
   assign decl_next = (decl_wide << 3) + (decl_wide << 1) + WIDE_BITS'(char_in[3:0]);

   always_comb begin
      phase_in       = phase_ff;
      declared_in    = declared_ff;
      empty_in       = empty_ff;
      obst_in        = obst_ff;
      full_in        = full_ff;
      first_width_in = first_width_ff;
      column_in      = column_ff;
      rows_in        = rows_ff;
      obs_total_in   = obs_total_ff;
      error_in       = error_ff;

      if (error_ff == ST_RUN) begin
         case (phase_ff)
            PH_FIRST_DIGIT, PH_DIGITS: begin
               if (is_digit) begin
                  declared_in = (decl_next > WIDE_BITS'(DIM_MAX)) ? DIM_MAX
                                                                  : decl_next[DIM_BITS-1:0];
                  phase_in    = PH_DIGITS;
               end else if (phase_ff == PH_FIRST_DIGIT) begin
                  error_in = ST_HEADER;
               end else begin
                  empty_in = char_in;
                  phase_in = PH_SYM_OBST;
               end
            end
            PH_SYM_OBST: begin
               obst_in  = char_in;
               phase_in = PH_SYM_FULL;
            end
            PH_SYM_FULL: begin
               full_in  = char_in;
               phase_in = PH_HDR_NL;
            end
            PH_HDR_NL: begin
               if (char_in == CHAR_NEWLINE) phase_in = PH_BODY;
               else                         error_in = ST_HEADER;
            end
            PH_BODY: begin
               if (char_in != CHAR_NEWLINE) begin
                  // obstacle wins when both symbols are the same byte
                  if (char_in == obst_ff || char_in == empty_ff) begin
                     if (char_in == obst_ff && obs_total_ff != COUNT_MAX)
                        obs_total_in = obs_total_ff + 1'b1;
                     if (column_ff != DIM_MAX) column_in = column_ff + 1'b1;
                  end else begin
                     error_in = ST_BADCHAR;
                  end
               end else if (rows_ff != '0 && column_ff != first_width_ff) begin
                  error_in = ST_WIDTH;
               end else begin
                  if (rows_ff == '0) first_width_in = column_ff;
                  column_in = '0;
                  if (rows_ff != DIM_MAX) rows_in = rows_ff + 1'b1;
               end
            end
            default: error_in = ST_HEADER;
         endcase
      end

      status = error_in;
      if (end_of_file && error_in == ST_RUN) begin
         if (phase_in != PH_BODY)       status = ST_HEADER;
         else if (rows_in != declared_in) status = ST_ROWS;
         else                           status = ST_VALID;
      end
   end

   assign result = '{
      status:          status,
      row_width:       ROW_FIELD_BITS'(first_width_in),
      rows_seen:       ROW_FIELD_BITS'(rows_in),
      obstacles_seen:  OBS_FIELD_BITS'(obs_total_in),
      empty_symbol:    empty_in,
      obstacle_symbol: obst_in,
      full_symbol:     full_in
   };

   always_ff @(posedge clock) begin
      if (reset || (take && end_of_file)) begin
         phase_ff       <= PH_FIRST_DIGIT;
         declared_ff    <= '0;
         empty_ff       <= '0;
         obst_ff        <= '0;
         full_ff        <= '0;
         first_width_ff <= '0;
         column_ff      <= '0;
         rows_ff        <= '0;
         obs_total_ff   <= '0;
         error_ff       <= ST_RUN;
      end else if (take) begin
         phase_ff       <= phase_in;
         declared_ff    <= declared_in;
         empty_ff       <= empty_in;
         obst_ff        <= obst_in;
         full_ff        <= full_in;
         first_width_ff <= first_width_in;
         column_ff      <= column_in;
         rows_ff        <= rows_in;
         obs_total_ff   <= obs_total_in;
         error_ff       <= error_in;
      end
   end

endmodule

`default_nettype wire
